/* design/assert_macros.svh */
// assertion macros for the checker in tcs_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// an expression that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// a same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// a next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants, register codes and the digit to segment map.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int COMP_STG  = 4;
  localparam int DISP_STG  = 4;
  localparam int NSTG      = COMP_STG + DISP_STG;
  localparam int CFG_IDX_W = 2;
  localparam int CENTI_MAX = 9999;

  localparam logic [7:0] SEG_POINT = 8'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_T1 = 2'd0,
    REG_CAL_T2 = 2'd1,
    REG_CAL_T3 = 2'd2
  } cfg_reg_t;

  function automatic logic [7:0] seg_of(input logic [3:0] dgt);
    logic [7:0] seg;
    unique case (dgt)
      4'd0:    seg = 8'b01111110;
      4'd1:    seg = 8'b00001100;
      4'd2:    seg = 8'b10110110;
      4'd3:    seg = 8'b10011110;
      4'd4:    seg = 8'b11001100;
      4'd5:    seg = 8'b11011010;
      4'd6:    seg = 8'b11111010;
      4'd7:    seg = 8'b00001110;
      4'd8:    seg = 8'b11111110;
      4'd9:    seg = 8'b11011110;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* design/tcs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_ctrl
// Valid bits of the pipeline and per-stage load enables with bubble collapse.
// ----------------------------------------------------------------------------
module tcs_ctrl
  import tcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic [NSTG-1:0] stage_en,
  output logic            last_valid
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    stage_en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stage_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall   = !stage_en[0];
  assign last_valid = vld_r[NSTG-1];

endmodule

/* design/tcs_comp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_comp
// Four-stage fine temperature path: offsets, products, shift and cal_t3 product, sum.
// ----------------------------------------------------------------------------
module tcs_comp
  import tcs_pkg::*;
(
  input  logic                clk,
  input  logic [COMP_STG-1:0] en,
  input  logic [19:0]         raw_reading,
  input  logic [15:0]         cal_t1,
  input  logic signed [15:0]  cal_t2,
  input  logic signed [15:0]  cal_t3,
  output logic signed [23:0]  fine
);

  // stage 1
  logic signed [17:0] a_r, a_nxt;
  logic signed [16:0] d_r, d_nxt;
  // stage 2
  logic signed [33:0] p1_r, p1_nxt;
  logic signed [33:0] dsq_full;
  logic [31:0]        dsq_r;
  // stage 3
  logic signed [22:0] var1_r, var1_nxt;
  logic signed [36:0] m2_r, m2_nxt;
  // stage 4
  logic signed [23:0] fine_r, fine_nxt;

  assign a_nxt = $signed({1'b0, raw_reading[19:3]}) - $signed({1'b0, cal_t1, 1'b0});
  assign d_nxt = $signed({1'b0, raw_reading[19:4]}) - $signed({1'b0, cal_t1});

  assign p1_nxt   = 34'(a_r) * 34'(cal_t2);
  assign dsq_full = 34'(d_r) * 34'(d_r);

  // floor shifts are plain part-selects of the signed products
  assign var1_nxt = $signed(p1_r[33:11]);
  assign m2_nxt   = 37'($signed({1'b0, dsq_r[31:12]})) * 37'(cal_t3);

  assign fine_nxt = 24'(var1_r) + 24'($signed(m2_r[36:14]));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= a_nxt;
      d_r <= d_nxt;
    end
    if (en[1]) begin
      p1_r  <= p1_nxt;
      dsq_r <= dsq_full[31:0];
    end
    if (en[2]) begin
      var1_r <= var1_nxt;
      m2_r   <= m2_nxt;
    end
    if (en[3]) begin
      fine_r <= fine_nxt;
    end
  end

  assign fine = fine_r;

endmodule

/* design/tcs_disp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_disp
// Four-stage display path: scale and saturate, then the thousands and hundreds
// digits one per stage, then the tens and units digits with segment lookup.
// ----------------------------------------------------------------------------
module tcs_disp
  import tcs_pkg::*;
(
  input  logic                clk,
  input  logic [DISP_STG-1:0] en,
  input  logic signed [23:0]  fine,
  output logic signed [22:0]  fine_temp,
  output logic [13:0]         centidegrees,
  output logic [7:0]          seg_tens,
  output logic [7:0]          seg_units,
  output logic [7:0]          seg_tenths,
  output logic [7:0]          seg_hundredths,
  output logic                out_of_range
);

  // stage 5
  logic signed [26:0] f5;
  logic signed [18:0] centi_full;
  logic signed [22:0] fine5_r;
  logic [13:0]        c5_r, c5_nxt;
  logic               oor5_r, oor5_nxt;
  // stage 6
  logic signed [22:0] fine6_r;
  logic [13:0]        c6_r;
  logic               oor6_r;
  logic [3:0]         th6_r, th6_nxt;
  logic [13:0]        th_base;
  logic [9:0]         rem6_r, rem6_nxt;
  // stage 7
  logic signed [22:0] fine7_r;
  logic [13:0]        c7_r;
  logic               oor7_r;
  logic [3:0]         th7_r;
  logic [3:0]         hu7_r, hu7_nxt;
  logic [9:0]         hu_base;
  logic [6:0]         rem7_r, rem7_nxt;
  // stage 8
  logic [3:0]         te_dig;
  logic [6:0]         te_base;
  logic [3:0]         on_dig;
  logic signed [22:0] fine8_r;
  logic [13:0]        c8_r;
  logic               oor8_r;
  logic [7:0]         seg_th_r, seg_hu_r, seg_te_r, seg_on_r;

  // fine * 5 / 256, floored
  always_comb begin
    f5         = (27'(fine) <<< 2) + 27'(fine);
    centi_full = $signed(f5[26:8]);
    if (centi_full[18]) begin
      c5_nxt   = '0;
      oor5_nxt = 1'b1;
    end else if (centi_full[17:0] > 18'(CENTI_MAX)) begin
      c5_nxt   = 14'(CENTI_MAX);
      oor5_nxt = 1'b1;
    end else begin
      c5_nxt   = centi_full[13:0];
      oor5_nxt = 1'b0;
    end
  end

  // thousands digit: independent compares, highest threshold met wins
  always_comb begin
    th6_nxt = '0;
    th_base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (c5_r >= 14'(k * 1000)) begin
        th6_nxt = 4'(k);
        th_base = 14'(k * 1000);
      end
    end
    rem6_nxt = 10'(c5_r - th_base);
  end

  always_comb begin
    hu7_nxt = '0;
    hu_base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem6_r >= 10'(k * 100)) begin
        hu7_nxt = 4'(k);
        hu_base = 10'(k * 100);
      end
    end
    rem7_nxt = 7'(rem6_r - hu_base);
  end

  always_comb begin
    te_dig  = '0;
    te_base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem7_r >= 7'(k * 10)) begin
        te_dig  = 4'(k);
        te_base = 7'(k * 10);
      end
    end
    on_dig = 4'(rem7_r - te_base);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fine5_r <= fine[22:0];
      c5_r    <= c5_nxt;
      oor5_r  <= oor5_nxt;
    end
    if (en[1]) begin
      fine6_r <= fine5_r;
      c6_r    <= c5_r;
      oor6_r  <= oor5_r;
      th6_r   <= th6_nxt;
      rem6_r  <= rem6_nxt;
    end
    if (en[2]) begin
      fine7_r <= fine6_r;
      c7_r    <= c6_r;
      oor7_r  <= oor6_r;
      th7_r   <= th6_r;
      hu7_r   <= hu7_nxt;
      rem7_r  <= rem7_nxt;
    end
    if (en[3]) begin
      fine8_r  <= fine7_r;
      c8_r     <= c7_r;
      oor8_r   <= oor7_r;
      seg_th_r <= seg_of(th7_r);
      seg_hu_r <= seg_of(hu7_r) | SEG_POINT;
      seg_te_r <= seg_of(te_dig);
      seg_on_r <= seg_of(on_dig);
    end
  end

  assign fine_temp      = fine8_r;
  assign centidegrees   = c8_r;
  assign seg_tens       = seg_th_r;
  assign seg_units      = seg_hu_r;
  assign seg_tenths     = seg_te_r;
  assign seg_hundredths = seg_on_r;
  assign out_of_range   = oor8_r;

endmodule

/* design/temp_compensate_to_seven_segment.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_compensate_to_seven_segment
// Raw temperature reading to fine temperature, centidegrees and four
// seven-segment digit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0..2 selects cal_t1, cal_t2, cal_t3; other indexes are
//   ignored. Write only while no request is in flight.
//   in channel: a request (in_raw_reading) is taken at an edge where in_valid
//   is high and in_stall is low.
//   out channel: one result per request, held while out_stall is high.
// Pipeline: eight register stages, four in tcs_comp and four in tcs_disp.
// Throughput: one request per cycle while in_stall is low; the eight-stage
//   pipeline has two 16-bit-class multiplies in stage two, one in stage three.
// Stall: each stage holds only when it is full and its successor holds, so
//   empty slots fill up while the output waits; in_stall rises once all
//   eight stages are full and out_stall is high.
// Reset: synchronous, active low; clears all valid bits and the calibration
//   registers to zero.
// ----------------------------------------------------------------------------
module temp_compensate_to_seven_segment
  import tcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [19:0]          in_raw_reading,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [22:0]   out_fine_temp,
  output logic [13:0]          out_centidegrees,
  output logic [7:0]           out_seg_tens,
  output logic [7:0]           out_seg_units,
  output logic [7:0]           out_seg_tenths,
  output logic [7:0]           out_seg_hundredths,
  output logic                 out_out_of_range
);

  logic [15:0]        cal_t1_r;
  logic signed [15:0] cal_t2_r;
  logic signed [15:0] cal_t3_r;
  logic [NSTG-1:0]    stage_en;
  logic signed [23:0] fine;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t1_r <= '0;
      cal_t2_r <= '0;
      cal_t3_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAL_T1: cal_t1_r <= cfg_data;
        REG_CAL_T2: cal_t2_r <= $signed(cfg_data);
        REG_CAL_T3: cal_t3_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  tcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .stage_en   (stage_en),
    .last_valid (out_valid)
  );

  tcs_comp u_comp (
    .clk         (clk),
    .en          (stage_en[COMP_STG-1:0]),
    .raw_reading (in_raw_reading),
    .cal_t1      (cal_t1_r),
    .cal_t2      (cal_t2_r),
    .cal_t3      (cal_t3_r),
    .fine        (fine)
  );

  tcs_disp u_disp (
    .clk            (clk),
    .en             (stage_en[NSTG-1:COMP_STG]),
    .fine           (fine),
    .fine_temp      (out_fine_temp),
    .centidegrees   (out_centidegrees),
    .seg_tens       (out_seg_tens),
    .seg_units      (out_seg_units),
    .seg_tenths     (out_seg_tenths),
    .seg_hundredths (out_seg_hundredths),
    .out_of_range   (out_out_of_range)
  );

endmodule

/* design/tcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcs_checker
  import tcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_centidegrees,
  input logic [7:0]  out_seg_units,
  input logic        out_out_of_range
);

  `ASSERT_IMPL(a_centi_max, out_valid, out_centidegrees <= 14'(CENTI_MAX), "centidegrees above max")
  `ASSERT_IMPL(a_units_point, out_valid, out_seg_units[0] == 1'b1, "units point bit missing")
  `ASSERT_IMPL(a_oor_sat, out_valid && out_out_of_range, out_centidegrees == 14'd0 || out_centidegrees == 14'(CENTI_MAX), "flagged result not saturated")
  `ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable(out_centidegrees), "stalled result changed")

endmodule

bind temp_compensate_to_seven_segment tcs_checker u_tcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_centidegrees (out_centidegrees),
  .out_seg_units    (out_seg_units),
  .out_out_of_range (out_out_of_range)
);

/* tb/tcs_readout_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_readout_checker
// Watches the calibration, reading and readout channels of the temperature
// to seven-segment block, keeps its own calibration copy, predicts every
// readout and compares each accepted one field by field in request order.
// ----------------------------------------------------------------------------
module tcs_readout_checker
  import tcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [19:0]          in_raw_reading,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [22:0]   out_fine_temp,
  input  logic [13:0]          out_centidegrees,
  input  logic [7:0]           out_seg_tens,
  input  logic [7:0]           out_seg_units,
  input  logic [7:0]           out_seg_tenths,
  input  logic [7:0]           out_seg_hundredths,
  input  logic                 out_out_of_range,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic signed [22:0] fine_temp;
    logic [13:0]        centidegrees;
    logic [7:0]         seg_tens;
    logic [7:0]         seg_units;
    logic [7:0]         seg_tenths;
    logic [7:0]         seg_hundredths;
    logic               out_of_range;
  } readout_t;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC, 8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE
  };

  logic [15:0] cal_t1, cal_t2, cal_t3;
  readout_t    readout_q[$];

  function automatic readout_t compensate_reading(input logic [19:0] raw);
    longint   r, t1, t2, t3, lin, d, quad, fine, centi;
    readout_t res;
    r  = longint'(raw);
    t1 = longint'(cal_t1);
    t2 = longint'($signed(cal_t2));
    t3 = longint'($signed(cal_t3));
    // arithmetic shifts on signed 64-bit values give the floor divisions
    lin  = (((r >>> 3) - 2 * t1) * t2) >>> 11;
    d    = (r >>> 4) - t1;
    quad = (((d * d) >>> 12) * t3) >>> 14;
    fine = lin + quad;
    centi = (fine * 5) >>> 8;
    res.out_of_range = (centi < 0) || (centi > CENTI_MAX);
    if (centi < 0) begin
      centi = 0;
    end else if (centi > CENTI_MAX) begin
      centi = CENTI_MAX;
    end
    res.fine_temp      = fine[22:0];
    res.centidegrees   = centi[13:0];
    res.seg_tens       = DIGIT_SEG[(centi / 1000) % 10];
    res.seg_units      = DIGIT_SEG[(centi / 100) % 10] | SEG_POINT;
    res.seg_tenths     = DIGIT_SEG[(centi / 10) % 10];
    res.seg_hundredths = DIGIT_SEG[centi % 10];
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    readout_t want;
    if (!rst_n) begin
      cal_t1 = '0;
      cal_t2 = '0;
      cal_t3 = '0;
      readout_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAL_T1: cal_t1 = cfg_data;
          REG_CAL_T2: cal_t2 = cfg_data;
          REG_CAL_T3: cal_t3 = cfg_data;
          default: ;  // unused index, write has no effect
        endcase
      end
      if (in_valid && !in_stall) begin
        readout_q.push_back(compensate_reading(in_raw_reading));
      end
      if (out_valid && !out_stall) begin
        if (readout_q.size() == 0) begin
          $error("readout with no request waiting");
          fail_count++;
        end else begin
          want = readout_q.pop_front();
          check_field("fine_temp", 64'(want.fine_temp), 64'(out_fine_temp));
          check_field("centidegrees", 64'(want.centidegrees), 64'(out_centidegrees));
          check_field("seg_tens", 64'(want.seg_tens), 64'(out_seg_tens));
          check_field("seg_units", 64'(want.seg_units), 64'(out_seg_units));
          check_field("seg_tenths", 64'(want.seg_tenths), 64'(out_seg_tenths));
          check_field("seg_hundredths", 64'(want.seg_hundredths),
                      64'(out_seg_hundredths));
          check_field("out_of_range", 64'(want.out_of_range), 64'(out_out_of_range));
        end
      end
    end
    pending = readout_q.size();
  end

endmodule

/* tb/temp_compensate_to_seven_segment_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_compensate_to_seven_segment_tb
// Drives calibration words and raw readings into the block with random gaps
// and output stalls, runs directed corner readings and calibration extremes,
// then random phases; the checker beside the block scores every readout.
// ----------------------------------------------------------------------------
module temp_compensate_to_seven_segment_tb;
  import tcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_PHASES      = 16;
  localparam int READINGS_PER_PHASE = 105;
  localparam int LONG_HOLD          = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [19:0]          in_raw_reading = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [22:0]   out_fine_temp;
  logic [13:0]          out_centidegrees;
  logic [7:0]           out_seg_tens;
  logic [7:0]           out_seg_units;
  logic [7:0]           out_seg_tenths;
  logic [7:0]           out_seg_hundredths;
  logic                 out_out_of_range;

  int fail_count;
  int pending;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_long_req;
  int cur_t1;
  int cur_t2;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  temp_compensate_to_seven_segment DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_reading     (in_raw_reading),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fine_temp      (out_fine_temp),
    .out_centidegrees   (out_centidegrees),
    .out_seg_tens       (out_seg_tens),
    .out_seg_units      (out_seg_units),
    .out_seg_tenths     (out_seg_tenths),
    .out_seg_hundredths (out_seg_hundredths),
    .out_out_of_range   (out_out_of_range)
  );

  tcs_readout_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_reading     (in_raw_reading),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fine_temp      (out_fine_temp),
    .out_centidegrees   (out_centidegrees),
    .out_seg_tens       (out_seg_tens),
    .out_seg_units      (out_seg_units),
    .out_seg_tenths     (out_seg_tenths),
    .out_seg_hundredths (out_seg_hundredths),
    .out_out_of_range   (out_out_of_range),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  function automatic int draw_gap(input bit idle_on);
    return idle_on ? int'($urandom_range(10, 0)) : 0;
  endfunction

  // mostly readings that land on the display range for the current calibration
  function automatic logic [19:0] pick_raw();
    longint base, span, lo, hi;
    if (cur_t2 > 100 && $urandom_range(9, 0) < 8) begin
      base = 16 * longint'(cur_t1);
      span = 64'd8388608000 / cur_t2;  // raw span of about 100 degrees
      lo = base - span / 10;
      hi = base + span + span / 10;
      if (lo < 0) lo = 0;
      if (hi > 1048575) hi = 1048575;
      if (lo <= hi) begin
        return 20'($urandom_range(int'(hi), int'(lo)));
      end
    end
    return 20'($urandom_range(1048575, 0));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_calibration(input int t1, input int t2, input int t3);
    write_reg(REG_CAL_T1, t1[15:0]);
    write_reg(REG_CAL_T2, t2[15:0]);
    write_reg(REG_CAL_T3, t3[15:0]);
    cur_t1 = t1;
    cur_t2 = t2;
  endtask

  task automatic send_reading(input logic [19:0] raw);
    int gap;
    gap = draw_gap(send_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_raw_reading <= raw;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // drop valid and let every outstanding readout come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stall before each readout, one long hold on demand
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      n = draw_gap(recv_idle_on);
      if (hold_long_req) begin
        n = LONG_HOLD;
        hold_long_req = 1'b0;
      end
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int kind;
    int t1, t2, t3;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // calibration at reset value: everything reads 00.00
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_reading(20'h00000);
    send_reading(20'hFFFFF);
    drain();
    // unused register index must leave the calibration alone
    write_reg(REG_SPARE, 16'hFFFF);
    send_reading(20'h80000);
    drain();

    // typical sensor calibration: in range, below zero, above 99.99
    set_calibration(27504, 26435, -1000);
    send_reading(20'd519888);
    send_reading(20'd440064);
    send_reading(20'd440000);
    send_reading(20'd500000);
    send_reading(20'd600000);
    send_reading(20'd700000);
    send_reading(20'd760000);
    send_reading(20'h00000);
    send_reading(20'hFFFFF);
    drain();

    // calibration extremes
    set_calibration(65535, 32767, 32767);
    send_reading(20'h00000);
    send_reading(20'hFFFFF);
    drain();
    set_calibration(0, -32768, -32768);
    send_reading(20'h00000);
    send_reading(20'hFFFFF);
    drain();
    set_calibration(65535, -32768, 32767);
    send_reading(20'hFFFFF);
    send_reading(20'h00000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        t1 = $urandom_range(34000, 20000);
        t2 = $urandom_range(30000, 20000);
        t3 = int'($urandom_range(6000, 0)) - 3000;
      end else if (kind < 9) begin
        t1 = $urandom_range(65535, 0);
        t2 = int'($urandom_range(65535, 0)) - 32768;
        t3 = int'($urandom_range(65535, 0)) - 32768;
      end else begin
        t1 = $urandom_range(1, 0) ? 65535 : 0;
        t2 = $urandom_range(1, 0) ? 32767 : -32768;
        t3 = $urandom_range(1, 0) ? 32767 : -32768;
      end
      set_calibration(t1, t2, t3);
      send_idle_on = (p != 0) && ($urandom_range(2, 0) != 0);
      recv_idle_on = (p != 0) && ($urandom_range(2, 0) != 0);
      if (p == 2) begin
        // back-to-back requests against a long output hold fill the pipeline
        send_idle_on  = 1'b0;
        hold_long_req = 1'b1;
      end
      for (int i = 0; i < READINGS_PER_PHASE; i++) begin
        send_reading(pick_raw());
      end
      drain();
    end

    repeat (2 * NSTG) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/tcs_pkg.sv
design/tcs_ctrl.sv
design/tcs_comp.sv
design/tcs_disp.sv
design/temp_compensate_to_seven_segment.sv
design/tcs_checker.sv
tb/tcs_readout_checker.sv
tb/temp_compensate_to_seven_segment_tb.sv
